// ===== src/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Needs nothing else; take it in by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock with an active-low reset.
`define BRD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
  else $error(msg);

// Same, on the block clock and reset.
`define BRD_ASSERT_CLK(lbl, prop, msg) \
  `BRD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/brd_pkg.sv =====
// Constants, request codes, types and index helpers for the ring deque.
// No dependencies; every other source file but assert_macros.svh imports this package.
package brd_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int OCC_W     = 7;
  localparam int POS_W     = 6;
  localparam int REQ_W     = 4;
  localparam int VALUE_W   = 32;

  localparam logic [OCC_W-1:0] MAX_ENTRIES_RST = OCC_W'(64);

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_DROP_FRONT = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DROP_BACK  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_READ_AT    = 4'd6;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CHECK_ROOM = 4'd8;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
  } brd_ram_req_t;

  // Slot of the entry at an offset from the head, modulo the capacity.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                               input logic [OCC_W-1:0] off);
    logic [OCC_W-1:0] off_m;
    logic [IDX_W:0]   sum;
    off_m = (off >= OCC_W'(CAPACITY)) ? off - OCC_W'(CAPACITY) : off;
    sum   = {1'b0, head} + (IDX_W+1)'(off_m);
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== src/brd_req_if.sv =====
// Request channel of the ring deque: valid, ready and the request fields.
// Depends on brd_pkg for the field widths.
interface brd_req_if;
  import brd_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [VALUE_W-1:0] value;
  logic [OCC_W-1:0]   count;
  logic [POS_W-1:0]   position;

  modport source (output valid, req_type, value, count, position, input ready);
  modport sink (input valid, req_type, value, count, position, output ready);
endinterface

// ===== src/brd_rsp_if.sv =====
// Response channel of the ring deque: valid, ready and the result fields.
// Depends on brd_pkg for the field widths.
interface brd_rsp_if;
  import brd_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [VALUE_W-1:0] read_value;
  logic [OCC_W-1:0]   dropped;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, ok, read_value, dropped, occupancy, input ready);
  modport sink (input valid, ok, read_value, dropped, occupancy, output ready);
endinterface

// ===== src/brd_ram.sv =====
// Entry store: one write port and one registered read port.
// Depends on brd_pkg for depth, word width and the port struct.
module brd_ram (
  input  logic                          clk_i,
  input  brd_pkg::brd_ram_req_t         req_i,
  output logic [brd_pkg::WORD_BITS-1:0] rdata_o
);
  import brd_pkg::*;

  logic [WORD_BITS-1:0] mem_q [CAPACITY];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/brd_ctrl.sv =====
// Deque control: head, occupancy and limit registers, request decode,
// store access and the result register. Depends on brd_pkg, both channel
// interfaces and assert_macros.svh.
`include "assert_macros.svh"

module brd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brd_pkg::OCC_W-1:0]     cfg_wdata_i,
  brd_req_if.sink                       req_i,
  brd_rsp_if.source                     rsp_o,
  output brd_pkg::brd_ram_req_t         ram_o,
  input  logic [brd_pkg::WORD_BITS-1:0] ram_rdata_i
);
  import brd_pkg::*;

  logic [OCC_W-1:0] max_q;
  logic [IDX_W-1:0] head_q, head_d;
  logic [OCC_W-1:0] cnt_q, cnt_d;
  logic             rsp_valid_q;
  logic             ok_q, ok_d;
  logic [OCC_W-1:0] dropped_q, dropped_d;
  logic [OCC_W-1:0] occ_q;
  logic             sel_q, sel_d;
  logic [OCC_W-1:0] lim;
  logic [OCC_W-1:0] drop_n;
  logic [OCC_W-1:0] cnt_left;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;
  logic             accept;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign lim      = (max_q > OCC_W'(CAPACITY)) ? OCC_W'(CAPACITY) : max_q;
  assign drop_n   = (req_i.count < cnt_q) ? req_i.count : cnt_q;
  assign cnt_left = cnt_q - drop_n;
  assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    ok_d        = 1'b0;
    dropped_d   = '0;
    sel_d       = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = slot_at(head_q, cnt_q);
    ram_o.wdata = WORD_BITS'(req_i.value);
    ram_o.re    = 1'b0;
    ram_o.raddr = head_q;
    if (accept) begin
      unique case (req_i.req_type) inside
        REQ_PUSH_BACK: begin
          if (cnt_q < lim) begin
            ram_o.we = 1'b1;
            cnt_d    = cnt_q + 1'b1;
            ok_d     = 1'b1;
          end
        end
        REQ_PUSH_FRONT: begin
          if (cnt_q < lim) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = head_dec;
            head_d      = head_dec;
            cnt_d       = cnt_q + 1'b1;
            ok_d        = 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (cnt_q != '0) begin
            ram_o.re = 1'b1;
            head_d   = head_inc;
            cnt_d    = cnt_q - 1'b1;
            ok_d     = 1'b1;
            sel_d    = 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (cnt_q != '0) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = slot_at(head_q, cnt_q - 1'b1);
            cnt_d       = cnt_q - 1'b1;
            ok_d        = 1'b1;
            sel_d       = 1'b1;
          end
        end
        REQ_DROP_FRONT, REQ_DROP_BACK: begin
          if (drop_n != '0) begin
            if (req_i.req_type == REQ_DROP_FRONT) begin
              head_d = slot_at(head_q, drop_n);
            end
            cnt_d = cnt_left;
            if (cnt_left == '0) begin
              head_d = '0;
            end
            ok_d      = 1'b1;
            dropped_d = drop_n;
          end
        end
        REQ_READ_AT: begin
          if (OCC_W'(req_i.position) < cnt_q) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = slot_at(head_q, OCC_W'(req_i.position));
            ok_d        = 1'b1;
            sel_d       = 1'b1;
          end
        end
        REQ_CLEAR: begin
          head_d = '0;
          cnt_d  = '0;
          ok_d   = 1'b1;
        end
        REQ_CHECK_ROOM: begin
          ok_d = ((OCC_W+1)'(cnt_q) + (OCC_W+1)'(req_i.count)) <= (OCC_W+1)'(lim);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MAX_ENTRIES_RST;
      head_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept) begin
        head_q      <= head_d;
        cnt_q       <= cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      dropped_q <= dropped_d;
      occ_q     <= cnt_d;
      sel_q     <= sel_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.ok         = ok_q;
  assign rsp_o.dropped    = dropped_q;
  assign rsp_o.occupancy  = occ_q;
  assign rsp_o.read_value = sel_q ? VALUE_W'(ram_rdata_i) : '0;

  `BRD_ASSERT_CLK(a_occ_bound, cnt_q <= OCC_W'(CAPACITY), "occupancy above capacity")
  `BRD_ASSERT_CLK(a_pop_occ, accept && req_i.req_type == REQ_POP_FRONT && cnt_q != '0 |=> rsp_o.valid && rsp_o.occupancy == $past(cnt_q) - 1'b1, "pop front occupancy wrong")
  `BRD_ASSERT_CLK(a_hold_stall, rsp_o.valid && !rsp_o.ready |-> !req_i.ready, "request taken while result stalled")
endmodule

// ===== src/bounded_ring_deque_core.sv =====
// Bounded ring deque top level: control plus a 64-entry synchronous store.
// A result beat is registered and follows in the cycle after its request beat is accepted.
// Throughput: one request per cycle; the single registered result stage
// holds further requests only while its beat waits to be taken.
// Reset: head and occupancy clear, max_entries returns to 64; store is not cleared.
module bounded_ring_deque_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [brd_pkg::OCC_W-1:0] cfg_wdata_i,
  brd_req_if.sink                   req_i,
  brd_rsp_if.source                 rsp_o
);
  import brd_pkg::*;

  brd_ram_req_t         ram_req;
  logic [WORD_BITS-1:0] ram_rdata;

  brd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  brd_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );
endmodule

// ===== verif/bounded_ring_deque_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounded_ring_deque_core: a deque predictor tracks
// every accepted request beat and each result beat is checked in order.
// Depends on brd_pkg, brd_req_if, brd_rsp_if and the core RTL.
module bounded_ring_deque_core_tb;
  import brd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 4'd9;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 4'd15;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES = 8;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] value;
    logic [OCC_W-1:0]   count;
    logic [POS_W-1:0]   position;
  } deque_req_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_value;
    logic [OCC_W-1:0]   dropped;
    logic [OCC_W-1:0]   occupancy;
  } deque_rsp_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [OCC_W-1:0] cfg_wdata;

  brd_req_if req_bus ();
  brd_rsp_if rsp_bus ();

  bounded_ring_deque_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // Shadow of the deque and its limit register.
  logic [VALUE_W-1:0] ring_mem [CAPACITY];
  logic [IDX_W-1:0]   ring_head;
  logic [OCC_W-1:0]   ring_fill;
  logic [OCC_W-1:0]   limit_reg;

  deque_rsp_t  outcome_q [$];
  int          fail_cnt;
  int unsigned cycle_cnt;
  bit          send_idle_en;
  bit          rsp_idle_en;
  int          rsp_hold_len;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [IDX_W-1:0] ring_slot(input logic [OCC_W-1:0] off);
    return ring_head + off[IDX_W-1:0];
  endfunction

  function automatic deque_rsp_t deque_outcome(input deque_req_t r);
    deque_rsp_t       e;
    int               lim;
    logic [OCC_W-1:0] n;
    e = '0;
    lim = (int'(limit_reg) > CAPACITY) ? CAPACITY : int'(limit_reg);
    case (r.kind)
      REQ_PUSH_BACK: begin
        if (int'(ring_fill) < lim) begin
          ring_mem[ring_slot(ring_fill)] = r.value;
          ring_fill++;
          e.ok = 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (int'(ring_fill) < lim) begin
          ring_head = ring_head - 1'b1;
          ring_mem[ring_head] = r.value;
          ring_fill++;
          e.ok = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (ring_fill > 0) begin
          e.read_value = ring_mem[ring_head];
          ring_head = ring_head + 1'b1;
          ring_fill--;
          e.ok = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (ring_fill > 0) begin
          ring_fill--;
          e.read_value = ring_mem[ring_slot(ring_fill)];
          e.ok = 1'b1;
        end
      end
      REQ_DROP_FRONT, REQ_DROP_BACK: begin
        n = (r.count < ring_fill) ? r.count : ring_fill;
        e.dropped = n;
        if (n > 0) begin
          if (r.kind == REQ_DROP_FRONT) ring_head = ring_slot(n);
          ring_fill = ring_fill - n;
          if (ring_fill == 0) ring_head = '0;
          e.ok = 1'b1;
        end
      end
      REQ_READ_AT: begin
        if ({1'b0, r.position} < ring_fill) begin
          e.read_value = ring_mem[ring_slot({1'b0, r.position})];
          e.ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        ring_head = '0;
        ring_fill = '0;
        e.ok = 1'b1;
      end
      REQ_CHECK_ROOM: e.ok = (int'(ring_fill) + int'(r.count) <= lim);
      default: ;
    endcase
    e.occupancy = ring_fill;
    return e;
  endfunction

  always @(posedge clk) begin : result_check
    deque_rsp_t got;
    deque_rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      got = '{ok: rsp_bus.ok, read_value: rsp_bus.read_value,
              dropped: rsp_bus.dropped, occupancy: rsp_bus.occupancy};
      if (outcome_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result beat: ok=%0d rd=%h dropped=%0d occ=%0d",
                   got.ok, got.read_value, got.dropped, got.occupancy);
      end else begin
        want = outcome_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result mismatch: exp ok=%0d rd=%h dropped=%0d occ=%0d, got ok=%0d rd=%h dropped=%0d occ=%0d",
                     want.ok, want.read_value, want.dropped, want.occupancy,
                     got.ok, got.read_value, got.dropped, got.occupancy);
        end
      end
    end
  end

  initial begin : rsp_drain
    int stall;
    rsp_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_hold_len > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (rsp_hold_len) @(posedge clk);
        rsp_hold_len = 0;
      end
      stall = rsp_idle_en ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_bus.valid && rsp_bus.ready));
    end
  end

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] value,
                          input logic [OCC_W-1:0] count, input logic [POS_W-1:0] position);
    int         gap;
    deque_req_t r;
    r = '{kind: kind, value: value, count: count, position: position};
    gap = send_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.value    <= value;
    req_bus.count    <= count;
    req_bus.position <= position;
    do @(posedge clk); while (!req_bus.ready);
    outcome_q.push_back(deque_outcome(r));
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_limit(input logic [OCC_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    limit_reg = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_edge_requests();
    send_req(REQ_POP_FRONT, '0, '0, '0);
    send_req(REQ_POP_BACK, '0, '0, '0);
    send_req(REQ_READ_AT, '0, '0, '0);
    send_req(REQ_DROP_FRONT, '0, 7'd0, '0);
    send_req(REQ_DROP_BACK, '0, 7'd5, '0);
    send_req(REQ_CHECK_ROOM, '0, 7'd64, '0);
    send_req(REQ_CHECK_ROOM, '0, 7'd127, '0);
    send_req(REQ_PUSH_BACK, 32'hFFFF_FFFF, '0, '0);
    send_req(REQ_PUSH_FRONT, 32'h0000_0000, '0, '0);
    send_req(REQ_PUSH_BACK, 32'hA5A5_A5A5, '0, '0);
    send_req(REQ_READ_AT, '0, '0, 6'd2);
    send_req(REQ_READ_AT, '0, '0, 6'd63);
    send_req(REQ_DROP_FRONT, '0, 7'd0, '0);
    send_req(REQ_UNKNOWN_LO, 32'h1234_5678, 7'd127, 6'd63);
    send_req(REQ_UNKNOWN_HI, '0, '0, '0);
    send_req(REQ_POP_FRONT, '0, '0, '0);
    send_req(REQ_POP_BACK, '0, '0, '0);
    send_req(REQ_PUSH_FRONT, 32'h5A5A_5A5A, '0, '0);
    send_req(REQ_DROP_BACK, '0, 7'd127, '0);
    send_req(REQ_PUSH_BACK, 32'h0000_0001, '0, '0);
    send_req(REQ_CLEAR, '0, '0, '0);
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    write_limit(7'd0);
    send_req(REQ_PUSH_BACK, 32'hDEAD_BEEF, '0, '0);
    send_req(REQ_PUSH_FRONT, 32'hDEAD_BEEF, '0, '0);
    send_req(REQ_CHECK_ROOM, '0, 7'd0, '0);
    send_req(REQ_CHECK_ROOM, '0, 7'd1, '0);
    wait_idle();
    write_limit(7'd3);
    repeat (4) send_req(REQ_PUSH_BACK, $urandom(), '0, '0);
    send_req(REQ_CHECK_ROOM, '0, 7'd0, '0);
    send_req(REQ_CHECK_ROOM, '0, 7'd1, '0);
    send_req(REQ_DROP_FRONT, '0, 7'd3, '0);
    wait_idle();
  endtask

  // Hold the result side off while pushes keep coming, so the core backs up.
  task automatic test_full_backpressure();
    write_limit(MAX_ENTRIES_RST);
    send_idle_en = 1'b0;
    rsp_hold_len = HOLD_CYCLES;
    repeat (70) send_req(REQ_PUSH_BACK, $urandom(), '0, '0);
    repeat (10) send_req(REQ_POP_FRONT, '0, '0, '0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [OCC_W-1:0] phase_limit [N_PHASES];
    int               push_pct [N_PHASES];
    logic [REQ_W-1:0] kind;
    logic [OCC_W-1:0] cnt;
    logic [POS_W-1:0] pos;
    int               sel;
    phase_limit = '{7'd127, 7'd64, 7'd0, 7'd65, 7'd1, 7'($urandom_range(2, 63)), 7'd127,
                    7'd64};
    push_pct = '{75, 50, 55, 80, 45, 60, 35, 65};
    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(phase_limit[p]);
      send_idle_en = (p % 3 != 1);
      rsp_idle_en  = (p % 4 != 2);
      for (int i = 0; i < 95; i++) begin
        sel = $urandom_range(0, 99);
        cnt = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 8)) : 7'($urandom());
        pos = (ring_fill > 0 && $urandom_range(0, 4) != 0) ?
              POS_W'($urandom_range(0, ring_fill - 1)) : POS_W'($urandom());
        if (sel < push_pct[p]) begin
          kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 35) kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
          else if (sel < 65) kind = REQ_READ_AT;
          else if (sel < 80) kind = $urandom_range(0, 1) ? REQ_DROP_FRONT : REQ_DROP_BACK;
          else if (sel < 92) kind = REQ_CHECK_ROOM;
          else if (sel < 95) kind = REQ_CLEAR;
          else kind = REQ_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        end
        if (kind == REQ_CHECK_ROOM && $urandom_range(0, 1))
          cnt = 7'($urandom_range(0, 70));
        send_req(kind, $urandom(), cnt, pos);
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = '0;
    req_bus.value    = '0;
    req_bus.count    = '0;
    req_bus.position = '0;
    ring_head        = '0;
    ring_fill        = '0;
    limit_reg        = MAX_ENTRIES_RST;
    fail_cnt         = 0;
    cycle_cnt        = 0;
    send_idle_en     = 1'b1;
    rsp_idle_en      = 1'b1;
    rsp_hold_len     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_requests();
    test_limit_extremes();
    test_full_backpressure();
    test_random_traffic();

    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bounded_ring_deque_core.f =====
+incdir+src
src/brd_pkg.sv
src/brd_req_if.sv
src/brd_rsp_if.sv
src/brd_ram.sv
src/brd_ctrl.sv
src/bounded_ring_deque_core.sv
verif/bounded_ring_deque_core_tb.sv
